// ===== src/ibmt_pkg.sv =====
// Shared types and constants for the input binding match table.
`timescale 1ns / 1ps

package ibmt_pkg;

  localparam int unsigned SourceW = 3;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned SlotW   = SourceW + CodeW;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned TotalW  = 9;

  typedef enum logic [1:0] {
    MODE_BIND    = 2'd0,
    MODE_UNBIND  = 2'd1,
    MODE_RESOLVE = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_SOURCE = 2'd2,
    ST_CODE   = 2'd3
  } status_e;

  typedef enum logic [SourceW-1:0] {
    SRC_KEY   = 3'd0,
    SRC_MOUSE = 3'd1,
    SRC_PAD   = 3'd2,
    SRC_AXIS  = 3'd3
  } source_e;

endpackage

// ===== src/ibmt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ibmt_ram #(
  parameter int unsigned Width = 19,
  parameter int unsigned Depth = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/input_binding_match_table.sv =====
// Top level of the input binding match table.
//
// Input channel (in_valid_i / in_stall_o) carries one operation per transfer:
// mode_i selects bind, unbind or resolve; action_index_i, source_i and code_i
// are its operands. Output channel (out_valid_o / out_stall_i) returns one
// result per operation: status, found flag, matched slot and bound count.
// Slot source/code pairs live in a RAM with registered read data; the bound
// marks and the bound count are flip-flops.
// Bind, unbind and no-op results are registered at the accepting edge.
// Resolve scans the RAM one slot per cycle from slot 0 and stops at the
// first matching slot or after the last slot, where its result is
// registered. No new operation is taken until the scan ends, since the
// scan uses the single RAM read port.
// An operation is taken only when the output register is empty or is being
// emptied in the same cycle; while the receiver stalls a waiting result, the
// input stalls too. Reset unbinds every slot and clears the count at once.
`timescale 1ns / 1ps

module input_binding_match_table
  import ibmt_pkg::*;
#(
  parameter int unsigned ACTIONS     = 32,
  parameter int unsigned KEY_CODES   = 512,
  parameter int unsigned MOUSE_CODES = 8,
  parameter int unsigned PAD_CODES   = 16,
  parameter int unsigned AXIS_CODES  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  logic [IndexW-1:0]   action_index_i,
  input  logic [SourceW-1:0]  source_i,
  input  logic [CodeW-1:0]    code_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic                found_o,
  output logic [IndexW-1:0]   matched_action_o,
  output logic [TotalW-1:0]   bound_total_o
);

  localparam int unsigned IW = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;
  localparam int unsigned CW = $clog2(ACTIONS + 1);
  localparam logic [IW-1:0] LastIdx = IW'(ACTIONS - 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e              state_q;
  logic [ACTIONS-1:0]  valid_q, valid_d;
  logic [CW-1:0]       tally_q, tally_d;
  logic [IW-1:0]       cmp_idx_q;
  logic [SourceW-1:0]  req_src_q;
  logic [CodeW-1:0]    req_code_q;

  logic                out_valid_q, out_valid_d;
  status_e             status_q;
  logic                found_q;
  logic [IndexW-1:0]   match_q;
  logic [TotalW-1:0]   total_q;

  logic                accept;
  mode_e               mode;
  logic [IW-1:0]       idx;
  logic                in_range;
  logic [CodeW:0]      limit;
  logic                src_ok;
  status_e             bind_status;
  logic                ram_we;
  logic [IW-1:0]       raddr;
  logic [SlotW-1:0]    rdata;
  logic                hit;
  logic                result_set;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign mode       = mode_e'(mode_i);
  assign idx        = action_index_i[IW-1:0];
  assign in_range   = {1'b0, action_index_i} < TotalW'(ACTIONS);

  always_comb begin
    src_ok = 1'b1;
    unique case (source_i)
      SRC_KEY:   limit = (CodeW+1)'(KEY_CODES);
      SRC_MOUSE: limit = (CodeW+1)'(MOUSE_CODES);
      SRC_PAD:   limit = (CodeW+1)'(PAD_CODES);
      SRC_AXIS:  limit = (CodeW+1)'(AXIS_CODES);
      default: begin
        limit  = '0;
        src_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (!in_range) begin
      bind_status = ST_RANGE;
    end else if (!src_ok) begin
      bind_status = ST_SOURCE;
    end else if ({1'b0, code_i} >= limit) begin
      bind_status = ST_CODE;
    end else begin
      bind_status = ST_OK;
    end
  end

  assign ram_we = accept && (mode == MODE_BIND) && (bind_status == ST_OK);

  // Bound marks and count; slot data itself goes to the RAM.
  always_comb begin
    valid_d = valid_q;
    tally_d = tally_q;
    if (accept && in_range) begin
      if (mode == MODE_BIND && bind_status == ST_OK) begin
        valid_d[idx] = 1'b1;
        if (!valid_q[idx]) tally_d = tally_q + 1'b1;
      end else if (mode == MODE_UNBIND && valid_q[idx]) begin
        valid_d[idx] = 1'b0;
        tally_d = tally_q - 1'b1;
      end
    end
  end

  // Slot 0 is read at the accepting edge; later slots follow one per cycle.
  assign raddr = (state_q == S_IDLE) ? '0 : cmp_idx_q + 1'b1;
  assign hit   = valid_q[cmp_idx_q] && (rdata == {req_src_q, req_code_q});

  // Output register loads on a non-resolve transfer or at the end of a scan.
  assign result_set  = (state_q == S_IDLE) ? (accept && mode != MODE_RESOLVE)
                                           : (hit || cmp_idx_q == LastIdx);
  assign out_valid_d = result_set || (out_valid_q && out_stall_i);

  ibmt_ram #(
    .Width (SlotW),
    .Depth (ACTIONS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx),
    .wdata_i ({source_i, code_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      tally_q     <= '0;
      cmp_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      tally_q     <= tally_d;
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            found_q <= 1'b0;
            match_q <= '0;
            total_q <= TotalW'(tally_d);
            if (mode == MODE_RESOLVE) begin
              req_src_q  <= source_i;
              req_code_q <= code_i;
              cmp_idx_q  <= '0;
              state_q    <= S_SCAN;
            end else begin
              status_q    <= (mode == MODE_BIND) ? bind_status
                           : (mode == MODE_UNBIND && !in_range) ? ST_RANGE : ST_OK;
            end
          end
        end
        S_SCAN: begin
          if (hit || cmp_idx_q == LastIdx) begin
            status_q    <= ST_OK;
            found_q     <= hit;
            match_q     <= hit ? IndexW'(cmp_idx_q) : '0;
            state_q     <= S_IDLE;
          end else begin
            cmp_idx_q <= cmp_idx_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_o          = found_q;
  assign matched_action_o = match_q;
  assign bound_total_o    = total_q;

  a_tally_matches_marks : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    32'(tally_q) == $countones(valid_q)
  ) else $error("bound count disagrees with bound marks");

  a_scan_output_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !out_valid_q
  ) else $error("output register busy during a resolve scan");

  a_found_is_ok : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (status_o == ST_OK)
  ) else $error("found result with error status");

  a_total_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(bound_total_o) <= ACTIONS)
  ) else $error("bound total exceeds slot count");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the input binding match table.
`timescale 1ns / 1ps

module testbench;
  import ibmt_pkg::*;

  localparam int ACTIONS     = 32;
  localparam int KEY_CODES   = 512;
  localparam int MOUSE_CODES = 8;
  localparam int PAD_CODES   = 16;
  localparam int AXIS_CODES  = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 100;

  typedef struct {
    mode_e               mode;
    logic [IndexW-1:0]   idx;
    status_e             status;
    logic                found;
    logic [IndexW-1:0]   matched;
    logic [TotalW-1:0]   total;
  } outcome_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i         = MODE_BIND;
  logic [IndexW-1:0]  action_index_i = '0;
  logic [SourceW-1:0] source_i       = '0;
  logic [CodeW-1:0]   code_i         = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [1:0]         status_o;
  logic               found_o;
  logic [IndexW-1:0]  matched_action_o;
  logic [TotalW-1:0]  bound_total_o;

  // shadow copy of the slot table
  bit                 shadow_bound [ACTIONS];
  logic [SourceW-1:0] shadow_src   [ACTIONS];
  logic [CodeW-1:0]   shadow_code  [ACTIONS];
  int                 shadow_tally = 0;

  outcome_t pending_outcomes[$];
  outcome_t want;

  bit idle_on      = 1'b1;
  int stall_left   = 0;
  int error_count  = 0;
  int cycle_count  = 0;
  int mode_count[4] = '{0, 0, 0, 0};
  int hit_count    = 0;
  int peak_tally   = 0;

  input_binding_match_table #(
    .ACTIONS    (ACTIONS),
    .KEY_CODES  (KEY_CODES),
    .MOUSE_CODES(MOUSE_CODES),
    .PAD_CODES  (PAD_CODES),
    .AXIS_CODES (AXIS_CODES)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .action_index_i  (action_index_i),
    .source_i        (source_i),
    .code_i          (code_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_o         (found_o),
    .matched_action_o(matched_action_o),
    .bound_total_o   (bound_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_outcomes.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // 0 means the source is not a known one
  function automatic int code_limit(logic [SourceW-1:0] src);
    case (src)
      SRC_KEY:   return KEY_CODES;
      SRC_MOUSE: return MOUSE_CODES;
      SRC_PAD:   return PAD_CODES;
      SRC_AXIS:  return AXIS_CODES;
      default:   return 0;
    endcase
  endfunction

  function automatic outcome_t predict_outcome(mode_e mode, logic [IndexW-1:0] idx,
                                               logic [SourceW-1:0] src,
                                               logic [CodeW-1:0] code);
    outcome_t res;
    int limit;
    res.mode    = mode;
    res.idx     = idx;
    res.status  = ST_OK;
    res.found   = 1'b0;
    res.matched = '0;
    limit = code_limit(src);
    case (mode)
      MODE_BIND: begin
        if (idx >= ACTIONS) res.status = ST_RANGE;
        else if (limit == 0) res.status = ST_SOURCE;
        else if (code >= limit) res.status = ST_CODE;
        else begin
          if (!shadow_bound[idx]) shadow_tally++;
          shadow_bound[idx] = 1'b1;
          shadow_src[idx]   = src;
          shadow_code[idx]  = code;
        end
      end
      MODE_UNBIND: begin
        if (idx >= ACTIONS) res.status = ST_RANGE;
        else if (shadow_bound[idx]) begin
          shadow_bound[idx] = 1'b0;
          shadow_src[idx]   = '0;
          shadow_code[idx]  = '0;
          shadow_tally--;
        end
      end
      MODE_RESOLVE: begin
        // scan downward so the last hit kept is the lowest slot
        for (int i = ACTIONS - 1; i >= 0; i--) begin
          if (shadow_bound[i] && shadow_src[i] == src && shadow_code[i] == code) begin
            res.found   = 1'b1;
            res.matched = IndexW'(i);
          end
        end
      end
      default: ;
    endcase
    res.total = TotalW'(shadow_tally);
    return res;
  endfunction

  function automatic int pick_bound_slot();
    int slots[$];
    for (int i = 0; i < ACTIONS; i++) if (shadow_bound[i]) slots.push_back(i);
    if (slots.size() == 0) return -1;
    return slots[$urandom_range(0, slots.size() - 1)];
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_LIMIT) $display("[%0t] MISMATCH %s", $realtime, what);
    error_count++;
  endtask

  // one transfer on the input side; valid stays high unless a gap is taken
  task automatic send_op(input mode_e mode, input logic [IndexW-1:0] idx,
                         input logic [SourceW-1:0] src, input logic [CodeW-1:0] code);
    outcome_t res;
    if (idle_on && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    action_index_i <= idx;
    source_i       <= src;
    code_i         <= code;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = predict_outcome(mode, idx, src, code);
    pending_outcomes.push_back(res);
    mode_count[mode]++;
    if (res.found) hit_count++;
    if (shadow_tally > peak_tally) peak_tally = shadow_tally;
  endtask

  task automatic random_op(input int bind_pct, input int unbind_pct);
    int unsigned roll;
    int pick;
    mode_e mode;
    logic [IndexW-1:0] idx;
    logic [SourceW-1:0] src;
    logic [CodeW-1:0] code;
    roll = $urandom_range(0, 99);
    if (roll < bind_pct) mode = MODE_BIND;
    else if (roll < bind_pct + unbind_pct) mode = MODE_UNBIND;
    else if (roll < 97) mode = MODE_RESOLVE;
    else mode = MODE_NOP;
    if ($urandom_range(0, 9) == 0) idx = IndexW'($urandom);
    else idx = IndexW'($urandom_range(0, ACTIONS - 1));
    src = SourceW'($urandom_range(0, 3));
    // a small code pool makes duplicate pairs, so the lowest-slot rule matters
    if ($urandom_range(0, 1) == 0) code = CodeW'($urandom_range(0, 3));
    else code = CodeW'($urandom_range(0, code_limit(src) - 1));
    if ($urandom_range(0, 9) == 0) begin
      src  = SourceW'($urandom);
      code = CodeW'($urandom);
    end
    pick = pick_bound_slot();
    if (pick >= 0 && $urandom_range(0, 99) < 60) begin
      if (mode == MODE_RESOLVE) begin
        src  = shadow_src[pick];
        code = shadow_code[pick];
      end else if (mode == MODE_UNBIND) begin
        idx = IndexW'(pick);
      end
    end
    send_op(mode, idx, src, code);
  endtask

  // result checker and receiver stall bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result transfer with nothing pending");
      end else begin
        want = pending_outcomes.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("%s idx %0d: status %0d, want %0d", want.mode.name(),
                                    want.idx, status_o, want.status));
        if (found_o !== want.found)
          report_mismatch($sformatf("%s idx %0d: found %0b, want %0b", want.mode.name(),
                                    want.idx, found_o, want.found));
        if (matched_action_o !== want.matched)
          report_mismatch($sformatf("%s idx %0d: matched %0d, want %0d", want.mode.name(),
                                    want.idx, matched_action_o, want.matched));
        if (bound_total_o !== want.total)
          report_mismatch($sformatf("%s idx %0d: bound total %0d, want %0d",
                                    want.mode.name(), want.idx, bound_total_o, want.total));
      end
    end
    if (!idle_on) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < 15) begin
      stall_left = $urandom_range(0, 8);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic test_bind_errors();
    send_op(MODE_BIND, 8'd32, SRC_KEY, 16'd0);
    send_op(MODE_BIND, 8'd255, 3'd7, 16'hFFFF);   // index is checked first
    send_op(MODE_BIND, 8'd0, 3'd4, 16'd0);
    send_op(MODE_BIND, 8'd0, 3'd7, 16'd0);
    send_op(MODE_BIND, 8'd0, SRC_KEY, 16'(KEY_CODES));
    send_op(MODE_BIND, 8'd0, SRC_MOUSE, 16'(MOUSE_CODES));
    send_op(MODE_BIND, 8'd0, SRC_PAD, 16'(PAD_CODES));
    send_op(MODE_BIND, 8'd0, SRC_AXIS, 16'(AXIS_CODES));
    send_op(MODE_BIND, 8'd0, SRC_KEY, 16'hFFFF);
  endtask

  task automatic test_bind_overwrite();
    send_op(MODE_BIND, 8'd0, SRC_KEY, 16'(KEY_CODES - 1));
    send_op(MODE_BIND, 8'(ACTIONS - 1), SRC_MOUSE, 16'(MOUSE_CODES - 1));
    send_op(MODE_BIND, 8'd5, SRC_PAD, 16'(PAD_CODES - 1));
    send_op(MODE_BIND, 8'd6, SRC_AXIS, 16'd0);
    send_op(MODE_BIND, 8'd0, SRC_AXIS, 16'(AXIS_CODES - 1));   // rebind, count holds
  endtask

  task automatic test_resolve_cases();
    send_op(MODE_RESOLVE, 8'd0, SRC_KEY, 16'(KEY_CODES - 1));   // overwritten pair
    send_op(MODE_RESOLVE, 8'd0, SRC_AXIS, 16'(AXIS_CODES - 1));
    send_op(MODE_BIND, 8'd3, SRC_MOUSE, 16'(MOUSE_CODES - 1));
    send_op(MODE_RESOLVE, 8'd0, SRC_MOUSE, 16'(MOUSE_CODES - 1));
    send_op(MODE_RESOLVE, 8'd0, 3'd6, 16'd7);
    send_op(MODE_RESOLVE, 8'd200, SRC_PAD, 16'(PAD_CODES - 1));
  endtask

  task automatic test_unbind_cases();
    send_op(MODE_UNBIND, 8'd3, 3'd7, 16'hFFFF);
    send_op(MODE_RESOLVE, 8'd0, SRC_MOUSE, 16'(MOUSE_CODES - 1));
    send_op(MODE_UNBIND, 8'd3, SRC_KEY, 16'd0);                 // already free
    send_op(MODE_UNBIND, 8'd40, SRC_KEY, 16'd0);
    send_op(MODE_UNBIND, 8'd255, 3'd7, 16'hFFFF);
  endtask

  task automatic test_nop_mode();
    send_op(MODE_NOP, 8'd255, 3'd7, 16'hFFFF);
    send_op(MODE_NOP, 8'd0, SRC_KEY, 16'd0);
  endtask

  task automatic test_fill_and_drain();
    repeat (90) random_op(75, 5);
    repeat (90) random_op(5, 75);
  endtask

  task automatic test_random_traffic();
    for (int chunk = 0; chunk < 7; chunk++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (50) random_op(35, 20);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (60) random_op(60, 10);
    repeat (60) random_op(25, 25);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bind_errors();
    test_bind_overwrite();
    test_resolve_cases();
    test_unbind_cases();
    test_nop_mode();
    test_fill_and_drain();
    test_random_traffic();
    test_back_to_back();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (ACTIONS + 8) @(posedge clk_i);
    $display("Ran %0d binds, %0d unbinds, %0d resolves (%0d hits) and %0d no-ops;",
             mode_count[MODE_BIND], mode_count[MODE_UNBIND], mode_count[MODE_RESOLVE],
             hit_count, mode_count[MODE_NOP]);
    $display("bound count peaked at %0d of %0d slots, %0d mismatches.", peak_tally,
             ACTIONS, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ibmt_pkg.sv
src/ibmt_ram.sv
src/input_binding_match_table.sv
bench/testbench.sv
